### rtl/esh_pkg.sv
// Shared types, codes and the kind table of the ELF segment header checker.
package esh_pkg;

	typedef logic [63:0] addr_t;
	typedef logic [31:0] word_t;

	localparam int KIND_COUNT = 12;
	localparam int TEXT_SLOT = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam int AW_W = 6;

	localparam logic [AW_W-1:0] AW_RESET = 6'd32;
	localparam addr_t BASE_RESET = 64'h0000_0000_0001_0000;
	localparam addr_t MASK_RESET = 64'h0000_0000_FFFF_FFFF;

	localparam logic REG_IDX_AW = 1'b0;
	localparam logic REG_IDX_BASE = 1'b1;

	localparam logic CMD_FINISH = 1'b1;

	localparam word_t PERM_X = 32'd1;
	localparam word_t PERM_W = 32'd2;
	localparam word_t PERM_R = 32'd4;

	localparam word_t TYPE_NULL = 32'd0;
	localparam word_t TYPE_LOAD = 32'd1;
	localparam word_t TYPE_DYNAMIC = 32'd2;
	localparam word_t TYPE_INTERP = 32'd3;
	localparam word_t TYPE_NOTE = 32'd4;
	localparam word_t TYPE_PHDR = 32'd6;
	localparam word_t TYPE_TLS = 32'd7;
	localparam word_t TYPE_EH_FRAME = 32'h6474_e550;
	localparam word_t TYPE_STACK = 32'h6474_e551;
	localparam word_t TYPE_RELRO = 32'h6474_e552;

	typedef enum logic [3:0] {
		ST_OK,
		ST_EMPTY,
		ST_IGNORED,
		ST_UNKNOWN,
		ST_DUPLICATE,
		ST_TEXT_ADDR,
		ST_TOO_LOW,
		ST_WRAP,
		ST_TOO_LARGE,
		ST_FILE_GT_MEM,
		ST_AFTER_ERROR,
		ST_NO_TEXT
	} esh_status_t;

	typedef enum logic [2:0] {
		ACT_IGNORE,
		ACT_TEXT,
		ACT_RO,
		ACT_RW,
		ACT_STACK
	} esh_act_t;

	typedef enum logic [1:0] {
		REGION_OTHER,
		REGION_TEXT,
		REGION_RO,
		REGION_RW
	} esh_region_t;

	localparam word_t KIND_TYPE [KIND_COUNT] = '{
		TYPE_PHDR, TYPE_LOAD, TYPE_LOAD, TYPE_LOAD, TYPE_TLS, TYPE_STACK,
		TYPE_DYNAMIC, TYPE_INTERP, TYPE_NOTE, TYPE_EH_FRAME, TYPE_RELRO, TYPE_NULL
	};

	localparam word_t KIND_PERMS [KIND_COUNT] = '{
		PERM_R, PERM_R | PERM_X, PERM_R, PERM_R | PERM_W, PERM_R, PERM_R | PERM_W,
		PERM_R, PERM_R, PERM_R, PERM_R, PERM_R, PERM_R
	};

	localparam esh_act_t KIND_ACT [KIND_COUNT] = '{
		ACT_IGNORE, ACT_TEXT, ACT_RO, ACT_RW, ACT_IGNORE, ACT_STACK,
		ACT_IGNORE, ACT_IGNORE, ACT_IGNORE, ACT_IGNORE, ACT_IGNORE, ACT_IGNORE
	};

	typedef struct packed {
		logic finish;
		logic empty;
		logic unknown;
		logic [KIND_COUNT-1:0] slot;
		esh_act_t act;
		esh_status_t pre_status;
		addr_t seg_start;
		addr_t seg_end;
		addr_t code_end;
	} esh_item_t;

endpackage

### rtl/elf_segment_header_checker_top.sv
// Top level of the ELF segment header checker: register port, front end, queue, back end.
//
// channel   direction  handshake            payload
// cfg       in         psel/penable/pready  paddr, pwdata, prdata
// in        in         in_valid/in_stall    cmd, seg_kind, seg_perms, seg_start, mem_size,
//                                           file_size
// out       out        out_valid/out_stall  status, will_load, region, code_limit, ro_begin,
//                                           ro_limit, rw_begin, rw_limit, top_address
//
// One request per cycle sustained while out_stall stays low; a taken request passes through the
// two-entry queue, then the result register, before its result is valid.
// Reset clears the image state, the queue and the result valid; registers return to
// address width 32 and base 0x10000.
// in_stall rises only when the queue is full; out_stall holds the result register and
// backs up into the queue.
module elf_segment_header_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [esh_pkg::PADDR_W-1:0] paddr,
	input  logic [esh_pkg::PDATA_W-1:0] pwdata,
	output logic [esh_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [31:0]                 seg_kind,
	input  logic [31:0]                 seg_perms,
	input  logic [63:0]                 seg_start,
	input  logic [63:0]                 mem_size,
	input  logic [63:0]                 file_size,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  status,
	output logic                        will_load,
	output logic [1:0]                  region,
	output logic [63:0]                 code_limit,
	output logic [63:0]                 ro_begin,
	output logic [63:0]                 ro_limit,
	output logic [63:0]                 rw_begin,
	output logic [63:0]                 rw_limit,
	output logic [63:0]                 top_address
);
	import esh_pkg::*;

	logic [AW_W-1:0] aw_q;
	addr_t base_q;
	addr_t mask_q;
	logic cfg_wr;

	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	esh_item_t front_item;
	esh_item_t queue_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= AW_RESET;
			base_q <= BASE_RESET;
			mask_q <= MASK_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_IDX_AW: begin
					aw_q <= pwdata[AW_W-1:0];
					mask_q <= (64'd1 << pwdata[AW_W-1:0]) - 64'd1;
				end
				REG_IDX_BASE: base_q <= pwdata;
				default: base_q <= base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_IDX_AW: prdata = {{(PDATA_W - AW_W){1'b0}}, aw_q};
			REG_IDX_BASE: prdata = base_q;
			default: prdata = '0;
		endcase
	end

	esh_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.seg_kind     (seg_kind),
		.seg_perms    (seg_perms),
		.seg_start    (seg_start),
		.mem_size     (mem_size),
		.file_size    (file_size),
		.base_address (base_q),
		.limit_mask   (mask_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.item         (front_item)
	);

	esh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.full      (q_full),
		.push_item (front_item),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_item  (queue_item)
	);

	esh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_q),
		.item_valid   (q_valid),
		.pop          (q_pop),
		.item         (queue_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.will_load    (will_load),
		.region       (region),
		.code_limit   (code_limit),
		.ro_begin     (ro_begin),
		.ro_limit     (ro_limit),
		.rw_begin     (rw_begin),
		.rw_limit     (rw_limit),
		.top_address  (top_address)
	);

	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && will_load) |-> (status == ST_OK))
		else $error("load flagged on a rejected header");

	a_ro_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && will_load && region == REGION_RO) |->
			(ro_begin < ro_limit && ro_limit <= top_address))
		else $error("read-only range inconsistent with top address");

	a_rw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && will_load && region == REGION_RW) |->
			(rw_begin < rw_limit && rw_limit <= top_address))
		else $error("read-write range inconsistent with top address");

endmodule

### rtl/esh_front.sv
// Front end: accepts a request, matches the kind table and runs the address checks.
module esh_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  esh_pkg::word_t     seg_kind,
	input  esh_pkg::word_t     seg_perms,
	input  esh_pkg::addr_t     seg_start,
	input  esh_pkg::addr_t     mem_size,
	input  esh_pkg::addr_t     file_size,
	input  esh_pkg::addr_t     base_address,
	input  esh_pkg::addr_t     limit_mask,
	input  logic               q_full,
	output logic               q_push,
	output esh_pkg::esh_item_t item
);
	import esh_pkg::*;

	logic [KIND_COUNT-1:0] hit;
	esh_act_t act;
	logic [64:0] sum;
	esh_status_t pre_status;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		hit = '0;
		act = ACT_IGNORE;
		for (int i = 0; i < KIND_COUNT; i++) begin
			if (seg_kind == KIND_TYPE[i] && seg_perms == KIND_PERMS[i]) begin
				hit[i] = 1'b1;
				act = KIND_ACT[i];
			end
		end
	end

	assign sum = {1'b0, seg_start} + {1'b0, mem_size};

	always_comb begin
		if (act == ACT_IGNORE) begin
			pre_status = ST_IGNORED;
		end else if (act == ACT_TEXT && seg_start != base_address) begin
			pre_status = ST_TEXT_ADDR;
		end else if (seg_start < base_address) begin
			pre_status = ST_TOO_LOW;
		end else if (sum[64]) begin
			pre_status = ST_WRAP;
		end else if ((sum[63:0] & ~limit_mask) != '0) begin
			pre_status = ST_TOO_LARGE;
		end else if (file_size > mem_size) begin
			pre_status = ST_FILE_GT_MEM;
		end else begin
			pre_status = ST_OK;
		end
	end

	always_comb begin
		item.finish = (cmd == CMD_FINISH);
		item.empty = (mem_size == '0);
		item.unknown = (hit == '0);
		item.slot = hit;
		item.act = act;
		item.pre_status = pre_status;
		item.seg_start = seg_start;
		item.seg_end = sum[63:0];
		item.code_end = base_address + file_size;
	end

endmodule

### rtl/esh_queue.sv
// Short request queue between the front end and the back end.
module esh_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  esh_pkg::esh_item_t   push_item,
	output logic                 pop_valid,
	input  logic                 pop,
	output esh_pkg::esh_item_t   pop_item
);
	import esh_pkg::*;

	esh_item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/esh_back.sv
// Back end: image state, duplicate and sticky error tracking, result register.
module esh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  esh_pkg::addr_t       base_address,
	input  logic                 item_valid,
	output logic                 pop,
	input  esh_pkg::esh_item_t   item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           status,
	output logic                 will_load,
	output logic [1:0]           region,
	output esh_pkg::addr_t       code_limit,
	output esh_pkg::addr_t       ro_begin,
	output esh_pkg::addr_t       ro_limit,
	output esh_pkg::addr_t       rw_begin,
	output esh_pkg::addr_t       rw_limit,
	output esh_pkg::addr_t       top_address
);
	import esh_pkg::*;

	logic [KIND_COUNT-1:0] kinds_q;
	logic open_q;
	addr_t high_q;
	addr_t code_end_q;
	addr_t ro_begin_q;
	addr_t ro_limit_q;
	addr_t rw_begin_q;
	addr_t rw_limit_q;
	esh_status_t first_err_q;

	logic out_valid_q;
	esh_status_t status_q;
	logic will_load_q;
	esh_region_t region_q;
	addr_t code_limit_q;
	addr_t ro_begin_out_q;
	addr_t ro_limit_out_q;
	addr_t rw_begin_out_q;
	addr_t rw_limit_out_q;
	addr_t top_q;

	addr_t cur_high;
	esh_status_t nxt_status;
	logic dup;
	logic mark;
	logic load;
	esh_region_t nxt_region;
	addr_t nxt_high;
	addr_t nxt_code;
	addr_t nxt_ro_begin;
	addr_t nxt_ro_limit;
	addr_t nxt_rw_begin;
	addr_t nxt_rw_limit;

	assign pop = item_valid && (!out_valid_q || !out_stall);

	assign cur_high = open_q ? high_q : base_address;
	assign dup = (kinds_q & item.slot) != '0;

	always_comb begin
		if (item.finish) begin
			if (first_err_q != ST_OK) begin
				nxt_status = first_err_q;
			end else if (!kinds_q[TEXT_SLOT]) begin
				nxt_status = ST_NO_TEXT;
			end else begin
				nxt_status = ST_OK;
			end
		end else if (first_err_q != ST_OK) begin
			nxt_status = ST_AFTER_ERROR;
		end else if (item.empty) begin
			nxt_status = ST_EMPTY;
		end else if (item.unknown) begin
			nxt_status = ST_UNKNOWN;
		end else if (dup) begin
			nxt_status = ST_DUPLICATE;
		end else begin
			nxt_status = item.pre_status;
		end
	end

	assign mark = !item.finish && first_err_q == ST_OK && !item.empty && !item.unknown && !dup;
	assign load = !item.finish && nxt_status == ST_OK;

	always_comb begin
		nxt_region = REGION_OTHER;
		nxt_high = cur_high;
		nxt_code = code_end_q;
		nxt_ro_begin = ro_begin_q;
		nxt_ro_limit = ro_limit_q;
		nxt_rw_begin = rw_begin_q;
		nxt_rw_limit = rw_limit_q;
		if (load) begin
			if (cur_high < item.seg_end) begin
				nxt_high = item.seg_end;
			end
			case (item.act)
				ACT_TEXT: begin
					nxt_code = item.code_end;
					nxt_region = REGION_TEXT;
				end
				ACT_RO: begin
					nxt_ro_begin = item.seg_start;
					nxt_ro_limit = item.seg_end;
					nxt_region = REGION_RO;
				end
				ACT_RW: begin
					nxt_rw_begin = item.seg_start;
					nxt_rw_limit = item.seg_end;
					nxt_region = REGION_RW;
				end
				default: nxt_region = REGION_OTHER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_q <= '0;
			open_q <= 1'b0;
			high_q <= '0;
			code_end_q <= '0;
			ro_begin_q <= '0;
			ro_limit_q <= '0;
			rw_begin_q <= '0;
			rw_limit_q <= '0;
			first_err_q <= ST_OK;
		end else if (pop) begin
			if (item.finish) begin
				kinds_q <= '0;
				open_q <= 1'b0;
				high_q <= '0;
				code_end_q <= '0;
				ro_begin_q <= '0;
				ro_limit_q <= '0;
				rw_begin_q <= '0;
				rw_limit_q <= '0;
				first_err_q <= ST_OK;
			end else begin
				open_q <= 1'b1;
				high_q <= nxt_high;
				code_end_q <= nxt_code;
				ro_begin_q <= nxt_ro_begin;
				ro_limit_q <= nxt_ro_limit;
				rw_begin_q <= nxt_rw_begin;
				rw_limit_q <= nxt_rw_limit;
				if (mark) begin
					kinds_q <= kinds_q | item.slot;
				end
				if (nxt_status >= ST_UNKNOWN && nxt_status <= ST_FILE_GT_MEM) begin
					first_err_q <= nxt_status;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= nxt_status;
			will_load_q <= load;
			region_q <= nxt_region;
			code_limit_q <= nxt_code;
			ro_begin_out_q <= nxt_ro_begin;
			ro_limit_out_q <= nxt_ro_limit;
			rw_begin_out_q <= nxt_rw_begin;
			rw_limit_out_q <= nxt_rw_limit;
			top_q <= nxt_high;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign will_load = will_load_q;
	assign region = region_q;
	assign code_limit = code_limit_q;
	assign ro_begin = ro_begin_out_q;
	assign ro_limit = ro_limit_out_q;
	assign rw_begin = rw_begin_out_q;
	assign rw_limit = rw_limit_out_q;
	assign top_address = top_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ELF segment header checker: directed images, then random ones.
module testbench;
	import esh_pkg::*;

	typedef enum int {
		K_PHDR, K_TEXT, K_RODATA, K_RWDATA, K_TLS, K_STACK,
		K_DYNAMIC, K_INTERP, K_NOTE, K_EH_FRAME, K_RELRO, K_NULL, K_NONE
	} kind_slot_t;

	typedef struct {
		esh_status_t status;
		logic        load;
		esh_region_t region;
		addr_t       code_limit;
		addr_t       ro_begin;
		addr_t       ro_limit;
		addr_t       rw_begin;
		addr_t       rw_limit;
		addr_t       top_address;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic [31:0]        seg_kind = '0;
	logic [31:0]        seg_perms = '0;
	logic [63:0]        seg_start = '0;
	logic [63:0]        mem_size = '0;
	logic [63:0]        file_size = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         status;
	logic               will_load;
	logic [1:0]         region;
	logic [63:0]        code_limit;
	logic [63:0]        ro_begin;
	logic [63:0]        ro_limit;
	logic [63:0]        rw_begin;
	logic [63:0]        rw_limit;
	logic [63:0]        top_address;

	logic [AW_W-1:0]       cfg_aw = AW_RESET;
	addr_t                 cfg_base = BASE_RESET;
	logic [KIND_COUNT-1:0] kinds_taken = '0;
	bit                    img_open = 1'b0;
	addr_t                 top_end = '0;
	addr_t                 code_end = '0;
	addr_t                 ro_lo = '0;
	addr_t                 ro_hi = '0;
	addr_t                 rw_lo = '0;
	addr_t                 rw_hi = '0;
	esh_status_t           first_err = ST_OK;

	verdict_t pending_verdicts[$];
	int       mismatches = 0;
	int       sent_count = 0;
	bit       calm = 1'b0;

	elf_segment_header_checker_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic addr_t wide_random();
		return {$urandom(), $urandom()};
	endfunction

	function automatic addr_t draw_below(addr_t lim);
		if (lim == 64'd0)
			return 64'd0;
		return wide_random() % lim;
	endfunction

	function automatic void kind_words(input kind_slot_t s, output word_t kind,
			output word_t perms);
		perms = PERM_R;
		case (s)
			K_PHDR: kind = TYPE_PHDR;
			K_TEXT: begin
				kind = TYPE_LOAD;
				perms = PERM_R | PERM_X;
			end
			K_RODATA: kind = TYPE_LOAD;
			K_RWDATA: begin
				kind = TYPE_LOAD;
				perms = PERM_R | PERM_W;
			end
			K_TLS: kind = TYPE_TLS;
			K_STACK: begin
				kind = TYPE_STACK;
				perms = PERM_R | PERM_W;
			end
			K_DYNAMIC: kind = TYPE_DYNAMIC;
			K_INTERP: kind = TYPE_INTERP;
			K_NOTE: kind = TYPE_NOTE;
			K_EH_FRAME: kind = TYPE_EH_FRAME;
			K_RELRO: kind = TYPE_RELRO;
			default: kind = TYPE_NULL;
		endcase
	endfunction

	function automatic verdict_t predict_verdict(logic op, word_t kind, word_t perms,
			addr_t start, addr_t msize, addr_t fsize);
		verdict_t    v;
		kind_slot_t  slot;
		esh_act_t    act;
		word_t       tk;
		word_t       tp;
		addr_t       seg_end;
		esh_status_t st;
		slot = K_NONE;
		for (int i = 0; i < KIND_COUNT; i++) begin
			kind_words(kind_slot_t'(i), tk, tp);
			if (tk == kind && tp == perms)
				slot = kind_slot_t'(i);
		end
		case (slot)
			K_TEXT: act = ACT_TEXT;
			K_RODATA: act = ACT_RO;
			K_RWDATA: act = ACT_RW;
			K_STACK: act = ACT_STACK;
			default: act = ACT_IGNORE;
		endcase
		v.load = 1'b0;
		v.region = REGION_OTHER;
		if (!img_open) begin
			img_open = 1'b1;
			top_end = cfg_base;
		end
		seg_end = start + msize;
		if (op == CMD_FINISH) begin
			if (first_err != ST_OK)
				st = first_err;
			else if (!kinds_taken[K_TEXT])
				st = ST_NO_TEXT;
			else
				st = ST_OK;
		end else if (first_err != ST_OK)
			st = ST_AFTER_ERROR;
		else if (msize == 64'd0)
			st = ST_EMPTY;
		else if (slot == K_NONE)
			st = ST_UNKNOWN;
		else if (kinds_taken[slot])
			st = ST_DUPLICATE;
		else begin
			kinds_taken[slot] = 1'b1;
			if (act == ACT_IGNORE)
				st = ST_IGNORED;
			else if (act == ACT_TEXT && start != cfg_base)
				st = ST_TEXT_ADDR;
			else if (start < cfg_base)
				st = ST_TOO_LOW;
			else if (seg_end < start)
				st = ST_WRAP;
			else if (seg_end >= (64'd1 << cfg_aw))
				st = ST_TOO_LARGE;
			else if (fsize > msize)
				st = ST_FILE_GT_MEM;
			else begin
				st = ST_OK;
				v.load = 1'b1;
				if (top_end < seg_end)
					top_end = seg_end;
				case (act)
					ACT_TEXT: begin
						code_end = cfg_base + fsize;
						v.region = REGION_TEXT;
					end
					ACT_RO: begin
						ro_lo = start;
						ro_hi = seg_end;
						v.region = REGION_RO;
					end
					ACT_RW: begin
						rw_lo = start;
						rw_hi = seg_end;
						v.region = REGION_RW;
					end
					default: v.region = REGION_OTHER;
				endcase
			end
		end
		if (op != CMD_FINISH && st >= ST_UNKNOWN && st <= ST_FILE_GT_MEM)
			first_err = st;
		v.status = st;
		v.code_limit = code_end;
		v.ro_begin = ro_lo;
		v.ro_limit = ro_hi;
		v.rw_begin = rw_lo;
		v.rw_limit = rw_hi;
		v.top_address = top_end;
		if (op == CMD_FINISH) begin
			kinds_taken = '0;
			img_open = 1'b0;
			top_end = '0;
			code_end = '0;
			ro_lo = '0;
			ro_hi = '0;
			rw_lo = '0;
			rw_hi = '0;
			first_err = ST_OK;
		end
		return v;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	task automatic send_request(logic op, word_t kind, word_t perms, addr_t start,
			addr_t msize, addr_t fsize);
		int gap;
		gap = calm ? 0 : int'($urandom_range(0, 4));
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = op;
		seg_kind = kind;
		seg_perms = perms;
		seg_start = start;
		mem_size = msize;
		file_size = fsize;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_verdicts.push_back(predict_verdict(op, kind, perms, start, msize, fsize));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_header(kind_slot_t s, addr_t start, addr_t msize, addr_t fsize);
		word_t kind;
		word_t perms;
		kind_words(s, kind, perms);
		send_request(~CMD_FINISH, kind, perms, start, msize, fsize);
	endtask

	task automatic send_finish();
		send_request(CMD_FINISH, $urandom(), $urandom(), wide_random(), wide_random(),
			wide_random());
	endtask

	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [PDATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_IDX_AW)
			cfg_aw = value[AW_W-1:0];
		else
			cfg_base = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_registers(logic [AW_W-1:0] aw, addr_t base);
		hold_until_drained();
		write_register(REG_IDX_AW, {{(PDATA_W-AW_W){1'b0}}, aw});
		write_register(REG_IDX_BASE, base);
	endtask

	task automatic test_clean_image();
		kind_slot_t ignored[8] = '{K_PHDR, K_TLS, K_DYNAMIC, K_INTERP, K_NOTE, K_EH_FRAME,
			K_RELRO, K_NULL};
		calm = 1'b1;
		send_header(K_TEXT, 64'h1_0000, 64'h2000, 64'h1800);
		send_header(K_RODATA, 64'h2_0000, 64'h1000, 64'h1000);
		send_header(K_RWDATA, 64'h3_0000, 64'h4000, 64'h100);
		send_header(K_STACK, 64'h4_0000, 64'h1_0000, 64'h0);
		foreach (ignored[i])
			send_header(ignored[i], 64'h400 * i, 64'h40 + i, 64'h40);
		send_header(K_TEXT, 64'h1_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_finish();
		calm = 1'b0;
	endtask

	task automatic test_header_errors();
		send_header(K_TEXT, 64'h1_0001, 64'h100, 64'h10);
		send_header(K_RODATA, 64'h2_0000, 64'h100, 64'h10);
		send_finish();
		send_header(K_RODATA, 64'h8000, 64'h100, 64'h10);
		send_finish();
		send_header(K_RWDATA, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'h0);
		send_finish();
		hold_until_drained();
		send_header(K_RODATA, 64'hFFFF_0000, 64'h1_0000, 64'h0);
		send_finish();
		send_header(K_RWDATA, 64'h2_0000, 64'h10, 64'h11);
		send_finish();
		send_request(~CMD_FINISH, TYPE_LOAD, PERM_W | PERM_X, 64'h1_0000, 64'h10, 64'h0);
		send_finish();
		send_header(K_TEXT, 64'h1_0000, 64'h100, 64'h100);
		send_header(K_TEXT, 64'h1_0000, 64'h100, 64'h100);
		send_finish();
		send_finish();
	endtask

	task automatic test_register_extremes();
		set_registers(6'd0, 64'h0);
		send_header(K_TEXT, 64'h0, 64'h1, 64'h0);
		send_finish();
		set_registers(6'd63, 64'h0);
		send_header(K_TEXT, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		send_header(K_RWDATA, 64'h0, 64'h1, 64'h0);
		send_finish();
		set_registers(6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
		send_header(K_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h0);
		send_finish();
		set_registers(6'd1, 64'h0);
		send_header(K_TEXT, 64'h0, 64'h1, 64'h1);
		send_finish();
	endtask

	task automatic run_random_image();
		kind_slot_t plan[$];
		kind_slot_t s;
		int         first;
		int         bad_at;
		int         pause_at;
		int         i;
		word_t      kind;
		word_t      perms;
		addr_t      limit;
		addr_t      room;
		addr_t      start;
		addr_t      msize;
		addr_t      fsize;
		bit         noisy;
		calm = ($urandom_range(0, 5) == 0);
		noisy = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) != 0)
			plan.push_back(K_TEXT);
		first = int'($urandom_range(0, KIND_COUNT - 1));
		for (i = 0; i < KIND_COUNT; i++) begin
			s = kind_slot_t'((first + i) % KIND_COUNT);
			if (s != K_TEXT && $urandom_range(0, 1) != 0)
				plan.push_back(s);
		end
		if (plan.size() != 0 && $urandom_range(0, 7) == 0)
			plan.push_back(plan[$urandom_range(0, plan.size() - 1)]);
		bad_at = noisy ? int'($urandom_range(0, plan.size())) : -1;
		pause_at = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, plan.size())) : -1;
		limit = 64'd1 << cfg_aw;
		room = (limit > cfg_base) ? limit - cfg_base : 64'd0;
		for (i = 0; i < plan.size(); i++) begin
			if (i == pause_at)
				hold_until_drained();
			kind_words(plan[i], kind, perms);
			if (plan[i] == K_TEXT) begin
				start = cfg_base;
				msize = 64'd1 + draw_below(room / 2);
			end else begin
				start = cfg_base + draw_below(room / 2);
				msize = 64'd1 + draw_below(room / 4);
			end
			fsize = draw_below(msize + 64'd1);
			if ($urandom_range(0, 9) == 0)
				msize = 64'd0;
			if (i == bad_at) begin
				case ($urandom_range(0, 5))
					0: start = wide_random();
					1: msize = wide_random();
					2: fsize = wide_random();
					3: perms = $urandom();
					4: kind = $urandom();
					default: begin
						kind = $urandom();
						perms = $urandom();
					end
				endcase
			end
			send_request(~CMD_FINISH, kind, perms, start, msize, fsize);
		end
		if (noisy && $urandom_range(0, 1) != 0)
			send_request(~CMD_FINISH, $urandom(), $urandom(), wide_random(), wide_random(),
				wide_random());
		send_finish();
	endtask

	task automatic test_random_images();
		int images;
		int aw;
		images = 0;
		while (sent_count < 1050) begin
			if (images % 12 == 0) begin
				case ($urandom_range(0, 4))
					0: set_registers(AW_RESET, BASE_RESET);
					1: begin
						aw = int'($urandom_range(1, 63));
						set_registers(AW_W'(aw), draw_below(64'd1 << (aw - 1)));
					end
					2: set_registers(6'd63, draw_below(64'd1 << 62));
					3: set_registers(AW_W'($urandom_range(0, 63)), wide_random());
					default: begin
						aw = int'($urandom_range(8, 40));
						set_registers(AW_W'(aw), draw_below(64'd1 << (aw - 4)) & ~64'hFFF);
					end
				endcase
			end
			run_random_image();
			images++;
		end
	endtask

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = calm ? 0 : int'($urandom_range(0, 4));
			if (hold != 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0)
				note_mismatch("result with nothing pending", 64'(status), 64'd0);
			else begin
				v = pending_verdicts.pop_front();
				if (status !== v.status)
					note_mismatch("status", 64'(status), 64'(v.status));
				if (will_load !== v.load)
					note_mismatch("will_load", 64'(will_load), 64'(v.load));
				if (region !== v.region)
					note_mismatch("region", 64'(region), 64'(v.region));
				if (code_limit !== v.code_limit)
					note_mismatch("code_limit", code_limit, v.code_limit);
				if (ro_begin !== v.ro_begin)
					note_mismatch("ro_begin", ro_begin, v.ro_begin);
				if (ro_limit !== v.ro_limit)
					note_mismatch("ro_limit", ro_limit, v.ro_limit);
				if (rw_begin !== v.rw_begin)
					note_mismatch("rw_begin", rw_begin, v.rw_begin);
				if (rw_limit !== v.rw_limit)
					note_mismatch("rw_limit", rw_limit, v.rw_limit);
				if (top_address !== v.top_address)
					note_mismatch("top_address", top_address, v.top_address);
			end
		end
	end

	initial begin
		int guard;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_clean_image();
		test_header_errors();
		test_register_extremes();
		test_random_images();
		in_valid = 1'b0;
		guard = 0;
		while (pending_verdicts.size() != 0 && guard < 4000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
		if (pending_verdicts.size() != 0)
			note_mismatch("results never arrived", 64'(pending_verdicts.size()), 64'd0);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
